// ----- hdl/ptwe_pkg.sv -----
// ptwe_pkg: primitive modes, pass-through codes and group control type
// shared by the edge generator, the top level and the checker
// no dependencies

package ptwe_pkg;

    // primitive modes as latched on the start flag
    localparam logic [3:0] MODE_POINTS    = 4'd0;
    localparam logic [3:0] MODE_LINES     = 4'd1;
    localparam logic [3:0] MODE_LOOP      = 4'd2;
    localparam logic [3:0] MODE_LSTRIP    = 4'd3;
    localparam logic [3:0] MODE_TRIS      = 4'd4;
    localparam logic [3:0] MODE_TSTRIP    = 4'd5;
    localparam logic [3:0] MODE_FAN       = 4'd6;
    localparam logic [3:0] MODE_QUADS     = 4'd7;
    localparam logic [3:0] MODE_QSTRIP    = 4'd8;
    localparam logic [3:0] MODE_POLYGON   = 4'd9;

    // pass-through modes on the result side
    localparam logic [1:0] PASS_POINTS    = 2'd0;
    localparam logic [1:0] PASS_LINES     = 2'd1;
    localparam logic [1:0] PASS_LOOP      = 2'd2;
    localparam logic [1:0] PASS_LSTRIP    = 2'd3;

    // result kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_PASS = 1'b1;

    // results one vertex can cause
    localparam int MAX_RESULTS = 4;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
    localparam int PTR_BITS    = $clog2(MAX_RESULTS);

    // control part of one vertex's result group
    typedef struct packed {
        logic [CNT_BITS-1:0] count;
        logic                kind;
        logic [1:0]          pass_mode;
    } group_ctrl_t;

endpackage

// ----- hdl/ptwe_edge_gen.sv -----
// ptwe_edge_gen: turns one vertex and the run state into its result group
// and the next run state; purely combinational
// depends on ptwe_pkg

module ptwe_edge_gen #(
    parameter int INDEX_BITS = 32
) (
    input  logic [INDEX_BITS-1:0] vertex_index,
    input  logic [3:0]            prim_mode,
    input  logic                  start_of_primitive,
    input  logic [3:0]            mode_cur,
    input  logic [INDEX_BITS-1:0] recent_cur [3],
    input  logic [INDEX_BITS-1:0] anchor_cur,
    input  logic [1:0]            seen_cur,
    input  logic [1:0]            phase_cur,
    output logic [3:0]            mode_nxt,
    output logic [INDEX_BITS-1:0] recent_nxt [3],
    output logic [INDEX_BITS-1:0] anchor_nxt,
    output logic [1:0]            seen_nxt,
    output logic [1:0]            phase_nxt,
    output ptwe_pkg::group_ctrl_t ctrl,
    output logic [INDEX_BITS-1:0] from_idx [ptwe_pkg::MAX_RESULTS],
    output logic [INDEX_BITS-1:0] to_idx [ptwe_pkg::MAX_RESULTS]
);

    logic [3:0]            mode;
    logic [1:0]            pos;
    logic [1:0]            ph;
    logic [INDEX_BITS-1:0] v;
    logic [INDEX_BITS-1:0] p1;
    logic [INDEX_BITS-1:0] p2;
    logic [INDEX_BITS-1:0] p3;
    logic [INDEX_BITS-1:0] anc;

    // a start restarts the run with cleared history
    always_comb
    begin
        v    = vertex_index;
        mode = start_of_primitive ? prim_mode : mode_cur;
        pos  = start_of_primitive ? 2'd0 : seen_cur;
        ph   = start_of_primitive ? 2'd0 : phase_cur;
        p1   = start_of_primitive ? '0 : recent_cur[0];
        p2   = start_of_primitive ? '0 : recent_cur[1];
        p3   = start_of_primitive ? '0 : recent_cur[2];
        anc  = start_of_primitive ? vertex_index : anchor_cur;
    end

    // history shift and saturating vertex count
    always_comb
    begin
        mode_nxt      = mode;
        recent_nxt[0] = v;
        recent_nxt[1] = p1;
        recent_nxt[2] = p2;
        anchor_nxt    = anc;
        seen_nxt      = (pos == 2'd3) ? 2'd3 : pos + 2'd1;
    end

    // result group and group phase per mode
    always_comb
    begin
        ctrl.count     = '0;
        ctrl.kind      = ptwe_pkg::KIND_EDGE;
        ctrl.pass_mode = ptwe_pkg::PASS_POINTS;
        phase_nxt      = ph;
        for (int k = 0; k < ptwe_pkg::MAX_RESULTS; k++)
        begin
            from_idx[k] = '0;
            to_idx[k]   = '0;
        end

        unique case (mode)
            ptwe_pkg::MODE_POINTS, ptwe_pkg::MODE_LINES,
            ptwe_pkg::MODE_LOOP, ptwe_pkg::MODE_LSTRIP:
            begin
                ctrl.count     = ptwe_pkg::CNT_BITS'(1);
                ctrl.kind      = ptwe_pkg::KIND_PASS;
                ctrl.pass_mode = mode[1:0];
                from_idx[0]    = v;
            end
            ptwe_pkg::MODE_POLYGON:
            begin
                ctrl.count     = ptwe_pkg::CNT_BITS'(1);
                ctrl.kind      = ptwe_pkg::KIND_PASS;
                ctrl.pass_mode = ptwe_pkg::PASS_LOOP;
                from_idx[0]    = v;
            end
            ptwe_pkg::MODE_TSTRIP:
            begin
                if (pos >= 2'd2)
                begin
                    ctrl.count  = ptwe_pkg::CNT_BITS'(2);
                    from_idx[0] = p2;
                    to_idx[0]   = v;
                    from_idx[1] = p1;
                    to_idx[1]   = v;
                end
                else if (pos == 2'd1)
                begin
                    ctrl.count  = ptwe_pkg::CNT_BITS'(1);
                    from_idx[0] = p1;
                    to_idx[0]   = v;
                end
            end
            ptwe_pkg::MODE_FAN:
            begin
                if (pos >= 2'd1)
                begin
                    ctrl.count  = (pos >= 2'd2) ? ptwe_pkg::CNT_BITS'(2)
                                                : ptwe_pkg::CNT_BITS'(1);
                    from_idx[0] = p1;
                    to_idx[0]   = v;
                    from_idx[1] = anc;
                    to_idx[1]   = v;
                end
            end
            ptwe_pkg::MODE_TRIS:
            begin
                if (ph >= 2'd2)
                begin
                    ctrl.count  = ptwe_pkg::CNT_BITS'(3);
                    from_idx[0] = p2;
                    to_idx[0]   = p1;
                    from_idx[1] = p1;
                    to_idx[1]   = v;
                    from_idx[2] = p2;
                    to_idx[2]   = v;
                    phase_nxt   = 2'd0;
                end
                else
                begin
                    phase_nxt = ph + 2'd1;
                end
            end
            ptwe_pkg::MODE_QUADS:
            begin
                if (ph == 2'd3)
                begin
                    ctrl.count  = ptwe_pkg::CNT_BITS'(4);
                    from_idx[0] = p3;
                    to_idx[0]   = p2;
                    from_idx[1] = p2;
                    to_idx[1]   = p1;
                    from_idx[2] = p1;
                    to_idx[2]   = v;
                    from_idx[3] = p3;
                    to_idx[3]   = v;
                end
                // wraps back to zero after the fourth corner
                phase_nxt = ph + 2'd1;
            end
            ptwe_pkg::MODE_QSTRIP:
            begin
                if (ph == 2'd0)
                begin
                    // first quad needs four vertices
                    if (pos == 2'd3)
                    begin
                        ctrl.count  = ptwe_pkg::CNT_BITS'(4);
                        from_idx[0] = p3;
                        to_idx[0]   = p2;
                        from_idx[1] = p3;
                        to_idx[1]   = p1;
                        from_idx[2] = p2;
                        to_idx[2]   = v;
                        from_idx[3] = p1;
                        to_idx[3]   = v;
                        phase_nxt   = 2'd1;
                    end
                end
                else if (ph == 2'd1)
                begin
                    phase_nxt = 2'd2;
                end
                else
                begin
                    ctrl.count  = ptwe_pkg::CNT_BITS'(3);
                    from_idx[0] = p3;
                    to_idx[0]   = p1;
                    from_idx[1] = p2;
                    to_idx[1]   = v;
                    from_idx[2] = p1;
                    to_idx[2]   = v;
                    phase_nxt   = 2'd1;
                end
            end
            default:
            begin
                // unknown modes give nothing, the vertex count still advances
            end
        endcase
    end

endmodule

// ----- hdl/primitive_to_wireframe_edges.sv -----
// primitive_to_wireframe_edges: top level, run state, result group and
// output register; depends on ptwe_pkg and ptwe_edge_gen
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  vertex   | vertex_valid, vertex_stall | vertex_index, prim_mode,
//           |                            | start_of_primitive, end_of_primitive
//  edge     | edge_valid, edge_stall     | result_kind, pass_mode, edge_from,
//           |                            | edge_to, primitive_end, last_of_run
//
// a vertex is decoded in its transfer cycle into a group of 0 to 4 results;
// the group hands one result per cycle to the output register while it
// is not stalled; a vertex holds the group until its last result leaves and one
// with none leaves it empty; results pass the group, then the output register
// the next vertex is taken in the cycle the group's last result moves out,
// so one result can wait stalled in the output register meanwhile
// reset clears the run state (points mode, empty history) and both stages

module primitive_to_wireframe_edges #(
    parameter int INDEX_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vertex_valid,
    output logic                  vertex_stall,
    input  logic [INDEX_BITS-1:0] vertex_index,
    input  logic [3:0]            prim_mode,
    input  logic                  start_of_primitive,
    input  logic                  end_of_primitive,
    output logic                  edge_valid,
    input  logic                  edge_stall,
    output logic                  result_kind,
    output logic [1:0]            pass_mode,
    output logic [INDEX_BITS-1:0] edge_from,
    output logic [INDEX_BITS-1:0] edge_to,
    output logic                  primitive_end,
    output logic                  last_of_run
);

    localparam int NRES = ptwe_pkg::MAX_RESULTS;
    localparam int CW   = ptwe_pkg::CNT_BITS;
    localparam int PW   = ptwe_pkg::PTR_BITS;

    // run state
    logic [3:0]            mode_reg;
    logic [INDEX_BITS-1:0] recent_reg [3];
    logic [INDEX_BITS-1:0] anchor_reg;
    logic [1:0]            seen_reg;
    logic [1:0]            phase_reg;

    logic [3:0]            mode_next;
    logic [INDEX_BITS-1:0] recent_next [3];
    logic [INDEX_BITS-1:0] anchor_next;
    logic [1:0]            seen_next;
    logic [1:0]            phase_next;

    // result group of the incoming vertex and of the vertex being unloaded
    ptwe_pkg::group_ctrl_t gen_ctrl;
    logic [INDEX_BITS-1:0] gen_from [NRES];
    logic [INDEX_BITS-1:0] gen_to [NRES];

    ptwe_pkg::group_ctrl_t grp_ctrl_reg;
    logic [PW-1:0]         grp_ptr_reg;
    logic                  grp_end_reg;
    logic [INDEX_BITS-1:0] grp_from_reg [NRES];
    logic [INDEX_BITS-1:0] grp_to_reg [NRES];

    // output register
    logic                  out_valid_reg;
    logic                  out_kind_reg;
    logic [1:0]            out_pass_reg;
    logic [INDEX_BITS-1:0] out_from_reg;
    logic [INDEX_BITS-1:0] out_to_reg;
    logic                  out_end_reg;
    logic                  out_last_reg;

    logic grp_valid;
    logic grp_last;
    logic out_free;
    logic grp_move;
    logic in_xfer;

    ptwe_edge_gen #(
        .INDEX_BITS (INDEX_BITS)
    ) u_edge_gen (
        .vertex_index       (vertex_index),
        .prim_mode          (prim_mode),
        .start_of_primitive (start_of_primitive),
        .mode_cur           (mode_reg),
        .recent_cur         (recent_reg),
        .anchor_cur         (anchor_reg),
        .seen_cur           (seen_reg),
        .phase_cur          (phase_reg),
        .mode_nxt           (mode_next),
        .recent_nxt         (recent_next),
        .anchor_nxt         (anchor_next),
        .seen_nxt           (seen_next),
        .phase_nxt          (phase_next),
        .ctrl               (gen_ctrl),
        .from_idx           (gen_from),
        .to_idx             (gen_to)
    );

    // handshake control
    always_comb
    begin
        grp_valid    = (grp_ctrl_reg.count != '0);
        grp_last     = ({1'b0, grp_ptr_reg} == CW'(grp_ctrl_reg.count - CW'(1)));
        out_free     = !out_valid_reg || !edge_stall;
        grp_move     = grp_valid && out_free;
        vertex_stall = grp_valid && !(grp_move && grp_last);
        in_xfer      = vertex_valid && !vertex_stall;
    end

    // run state update on each vertex transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ptwe_pkg::MODE_POINTS;
            anchor_reg <= '0;
            seen_reg   <= 2'd0;
            phase_reg  <= 2'd0;
            for (int k = 0; k < 3; k++)
            begin
                recent_reg[k] <= '0;
            end
        end
        else if (in_xfer)
        begin
            mode_reg   <= mode_next;
            anchor_reg <= anchor_next;
            seen_reg   <= seen_next;
            phase_reg  <= phase_next;
            for (int k = 0; k < 3; k++)
            begin
                recent_reg[k] <= recent_next[k];
            end
        end
    end

    // group control: load on transfer, step the pointer as results leave
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_ctrl_reg <= '0;
            grp_ptr_reg  <= '0;
        end
        else if (in_xfer)
        begin
            grp_ctrl_reg <= gen_ctrl;
            grp_ptr_reg  <= '0;
        end
        else if (grp_move)
        begin
            if (grp_last)
            begin
                grp_ctrl_reg.count <= '0;
            end
            else
            begin
                grp_ptr_reg <= grp_ptr_reg + PW'(1);
            end
        end
    end

    // group payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            grp_end_reg  <= end_of_primitive;
            grp_from_reg <= gen_from;
            grp_to_reg   <= gen_to;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= grp_valid;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (grp_move)
        begin
            out_kind_reg <= grp_ctrl_reg.kind;
            out_pass_reg <= grp_ctrl_reg.pass_mode;
            out_from_reg <= grp_from_reg[grp_ptr_reg];
            out_to_reg   <= grp_to_reg[grp_ptr_reg];
            out_end_reg  <= grp_end_reg && grp_last;
            out_last_reg <= grp_last;
        end
    end

    assign edge_valid    = out_valid_reg;
    assign result_kind   = out_kind_reg;
    assign pass_mode     = out_pass_reg;
    assign edge_from     = out_from_reg;
    assign edge_to       = out_to_reg;
    assign primitive_end = out_end_reg;
    assign last_of_run   = out_last_reg;

endmodule

// ----- hdl/ptwe_checker.sv -----
// ptwe_checker: port-level assertions on the result channel
// depends on ptwe_pkg; bound to primitive_to_wireframe_edges below

module ptwe_checker #(
    parameter int INDEX_BITS = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  edge_valid,
    input logic                  edge_stall,
    input logic                  result_kind,
    input logic [1:0]            pass_mode,
    input logic [INDEX_BITS-1:0] edge_to,
    input logic                  primitive_end,
    input logic                  last_of_run
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && edge_stall |=> edge_valid)
        else $error("result dropped while stalled");

    // a passed-through vertex is a single result with no second endpoint
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && (result_kind == ptwe_pkg::KIND_PASS) |->
            (edge_to == '0) && last_of_run)
        else $error("passthrough result malformed");

    // edges carry no pass-through mode
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && (result_kind == ptwe_pkg::KIND_EDGE) |->
            (pass_mode == ptwe_pkg::PASS_POINTS))
        else $error("edge carries a pass mode");

    // end flag only on the last result of a vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && primitive_end |-> last_of_run)
        else $error("end flag not on last result");

endmodule

bind primitive_to_wireframe_edges ptwe_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_ptwe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .edge_valid    (edge_valid),
    .edge_stall    (edge_stall),
    .result_kind   (result_kind),
    .pass_mode     (pass_mode),
    .edge_to       (edge_to),
    .primitive_end (primitive_end),
    .last_of_run   (last_of_run)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for primitive_to_wireframe_edges, with a clocked
// vertex driver, an edge monitor and an in-bench edge predictor
// depends on ptwe_pkg and the primitive_to_wireframe_edges rtl

module tb_top;

    localparam int IDX_W          = 32;
    localparam int RANDOM_ITEMS   = 95;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // one vertex transfer as queued for the driver
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [3:0]       mode;
        logic             sop;
        logic             eop;
        logic             drain_first;
    } vertex_t;

    // one edge-side transfer
    typedef struct packed {
        logic             kind;
        logic [1:0]       pmode;
        logic [IDX_W-1:0] e_from;
        logic [IDX_W-1:0] e_to;
        logic             pend;
        logic             last;
    } edge_rec_t;

    logic             clk;
    logic             rst_n;
    logic             vertex_valid;
    logic             vertex_stall;
    logic [IDX_W-1:0] vertex_index;
    logic [3:0]       prim_mode;
    logic             start_of_primitive;
    logic             end_of_primitive;
    logic             edge_valid;
    logic             edge_stall;
    logic             result_kind;
    logic [1:0]       pass_mode;
    logic [IDX_W-1:0] edge_from;
    logic [IDX_W-1:0] edge_to;
    logic             primitive_end;
    logic             last_of_run;

    vertex_t   vertex_q[$];
    edge_rec_t due_edges[$];

    // predictor copy of the run state
    logic [3:0]       run_mode;
    logic [IDX_W-1:0] recent [3];
    logic [IDX_W-1:0] anchor;
    logic [1:0]       seen;
    logic [1:0]       phase;

    int      n_sent;
    int      n_expected;
    int      n_checked;
    int      total_items;
    int      mismatches;
    int      burst_left;
    int      gap_left;
    int      stall_win;
    int      stall_pct;
    int      idle_cycles;
    vertex_t cur_vertex;

    primitive_to_wireframe_edges #(
        .INDEX_BITS(IDX_W)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .vertex_valid       (vertex_valid),
        .vertex_stall       (vertex_stall),
        .vertex_index       (vertex_index),
        .prim_mode          (prim_mode),
        .start_of_primitive (start_of_primitive),
        .end_of_primitive   (end_of_primitive),
        .edge_valid         (edge_valid),
        .edge_stall         (edge_stall),
        .result_kind        (result_kind),
        .pass_mode          (pass_mode),
        .edge_from          (edge_from),
        .edge_to            (edge_to),
        .primitive_end      (primitive_end),
        .last_of_run        (last_of_run)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic edge_rec_t make_edge(input logic [IDX_W-1:0] a,
                                            input logic [IDX_W-1:0] b);
        edge_rec_t rec;
        rec        = '0;
        rec.kind   = ptwe_pkg::KIND_EDGE;
        rec.e_from = a;
        rec.e_to   = b;
        return rec;
    endfunction

    // expected edges for one accepted vertex, in batch-conversion order
    function automatic int derive_edges(input vertex_t vt);
        edge_rec_t        grp[$];
        edge_rec_t        rec;
        logic [IDX_W-1:0] p1;
        logic [IDX_W-1:0] p2;
        logic [IDX_W-1:0] p3;
        logic [IDX_W-1:0] v;
        logic [1:0]       pos;
        logic [1:0]       ph;
        v = vt.idx;
        if (vt.sop)
        begin
            run_mode  = vt.mode;
            seen      = '0;
            phase     = '0;
            recent[0] = '0;
            recent[1] = '0;
            recent[2] = '0;
            anchor    = v;
        end
        pos = seen;
        ph  = phase;
        p1  = recent[0];
        p2  = recent[1];
        p3  = recent[2];
        case (run_mode)
            ptwe_pkg::MODE_POINTS, ptwe_pkg::MODE_LINES, ptwe_pkg::MODE_LOOP,
            ptwe_pkg::MODE_LSTRIP, ptwe_pkg::MODE_POLYGON:
            begin
                rec        = '0;
                rec.kind   = ptwe_pkg::KIND_PASS;
                rec.e_from = v;
                case (run_mode)
                    ptwe_pkg::MODE_POINTS: rec.pmode = ptwe_pkg::PASS_POINTS;
                    ptwe_pkg::MODE_LINES:  rec.pmode = ptwe_pkg::PASS_LINES;
                    ptwe_pkg::MODE_LSTRIP: rec.pmode = ptwe_pkg::PASS_LSTRIP;
                    default:               rec.pmode = ptwe_pkg::PASS_LOOP;
                endcase
                grp.push_back(rec);
            end
            ptwe_pkg::MODE_TSTRIP:
            begin
                if (pos >= 2) grp.push_back(make_edge(p2, v));
                if (pos >= 1) grp.push_back(make_edge(p1, v));
            end
            ptwe_pkg::MODE_FAN:
            begin
                if (pos >= 1) grp.push_back(make_edge(p1, v));
                if (pos >= 2) grp.push_back(make_edge(anchor, v));
            end
            ptwe_pkg::MODE_TRIS:
            begin
                if (ph >= 2)
                begin
                    grp.push_back(make_edge(p2, p1));
                    grp.push_back(make_edge(p1, v));
                    grp.push_back(make_edge(p2, v));
                    phase = 2'd0;
                end
                else
                begin
                    phase = ph + 2'd1;
                end
            end
            ptwe_pkg::MODE_QUADS:
            begin
                if (ph == 2'd3)
                begin
                    grp.push_back(make_edge(p3, p2));
                    grp.push_back(make_edge(p2, p1));
                    grp.push_back(make_edge(p1, v));
                    grp.push_back(make_edge(p3, v));
                end
                phase = ph + 2'd1;
            end
            ptwe_pkg::MODE_QSTRIP:
            begin
                if (ph == 2'd0)
                begin
                    // first quad closes on the fourth vertex
                    if (pos == 2'd3)
                    begin
                        grp.push_back(make_edge(p3, p2));
                        grp.push_back(make_edge(p3, p1));
                        grp.push_back(make_edge(p2, v));
                        grp.push_back(make_edge(p1, v));
                        phase = 2'd1;
                    end
                end
                else if (ph == 2'd1)
                begin
                    phase = 2'd2;
                end
                else
                begin
                    grp.push_back(make_edge(p3, p1));
                    grp.push_back(make_edge(p2, v));
                    grp.push_back(make_edge(p1, v));
                    phase = 2'd1;
                end
            end
            default:
            begin
            end
        endcase
        recent[2] = p2;
        recent[1] = p1;
        recent[0] = v;
        if (seen != 2'd3) seen = seen + 2'd1;
        // end flag and run marker ride on the last edge of the vertex
        if (grp.size() > 0)
        begin
            rec      = grp.pop_back();
            rec.pend = vt.eop;
            rec.last = 1'b1;
            grp.push_back(rec);
        end
        foreach (grp[i]) due_edges.push_back(grp[i]);
        return grp.size();
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 3))
            0:       return IDX_W'($urandom_range(0, 15));
            1:       return {IDX_W{1'b1}} - IDX_W'($urandom_range(0, 15));
            default: return IDX_W'($urandom);
        endcase
    endfunction

    task automatic queue_vertex(input logic [IDX_W-1:0] idx, input logic [3:0] mode,
                                input logic sop, input logic eop);
        vertex_t vt;
        vt.idx         = idx;
        vt.mode        = mode;
        vt.sop         = sop;
        vt.eop         = eop;
        vt.drain_first = ($urandom_range(0, 39) == 0);
        vertex_q.push_back(vt);
    endtask

    // one run with random indices; mode only counts on the first vertex
    task automatic queue_run(input logic [3:0] mode, input int len, input bit with_end);
        for (int i = 0; i < len; i++)
            queue_vertex(pick_index(), (i == 0) ? mode : 4'($urandom),
                         i == 0, with_end && (i == len - 1));
    endtask

    // stimulus and end of run
    initial
    begin
        int         n_random;
        int         len;
        int         hold_at;
        logic [3:0] mode;

        rst_n = 1'b0;

        // no start since reset: points mode, mode field ignored
        queue_vertex(32'hFFFF_FFFF, ptwe_pkg::MODE_QUADS, 1'b0, 1'b1);
        queue_vertex(32'h0000_0000, ptwe_pkg::MODE_LINES, 1'b1, 1'b0);
        queue_vertex(32'hFFFF_FFFF, ptwe_pkg::MODE_LOOP, 1'b1, 1'b1);
        queue_vertex(32'h8000_0001, ptwe_pkg::MODE_LSTRIP, 1'b1, 1'b1);
        // polygon turns into line loop
        queue_vertex(32'h0000_0010, ptwe_pkg::MODE_POLYGON, 1'b1, 1'b0);
        queue_vertex(32'h0000_0011, ptwe_pkg::MODE_POINTS, 1'b0, 1'b1);
        // triangles with a partial trailing group, end flag on a silent vertex
        queue_vertex(32'h0000_0000, ptwe_pkg::MODE_TRIS, 1'b1, 1'b0);
        queue_vertex(32'hFFFF_FFFF, ptwe_pkg::MODE_TRIS, 1'b0, 1'b0);
        queue_vertex(32'h0000_0005, ptwe_pkg::MODE_TRIS, 1'b0, 1'b0);
        queue_vertex(32'h0000_0006, ptwe_pkg::MODE_TRIS, 1'b0, 1'b1);
        // triangle strip, then one vertex continuing past the end flag
        queue_vertex(32'h0000_000A, ptwe_pkg::MODE_TSTRIP, 1'b1, 1'b0);
        queue_vertex(32'hFFFF_FFF0, ptwe_pkg::MODE_TSTRIP, 1'b0, 1'b0);
        queue_vertex(32'h0000_000C, ptwe_pkg::MODE_TSTRIP, 1'b0, 1'b1);
        queue_vertex(32'h0000_000D, ptwe_pkg::MODE_POINTS, 1'b0, 1'b1);
        queue_vertex(32'h0000_00F0, ptwe_pkg::MODE_FAN, 1'b1, 1'b0);
        queue_vertex(32'h0000_00F1, ptwe_pkg::MODE_FAN, 1'b0, 1'b0);
        queue_vertex(32'hFFFF_FFFF, ptwe_pkg::MODE_FAN, 1'b0, 1'b1);
        queue_vertex(32'h0000_0001, ptwe_pkg::MODE_QUADS, 1'b1, 1'b0);
        queue_vertex(32'h0000_0002, ptwe_pkg::MODE_QUADS, 1'b0, 1'b0);
        queue_vertex(32'hFFFF_FFFE, ptwe_pkg::MODE_QUADS, 1'b0, 1'b0);
        queue_vertex(32'h0000_0004, ptwe_pkg::MODE_QUADS, 1'b0, 1'b1);
        // quad strip under four vertices stays silent
        queue_vertex(32'h0000_0020, ptwe_pkg::MODE_QSTRIP, 1'b1, 1'b0);
        queue_vertex(32'h0000_0021, ptwe_pkg::MODE_QSTRIP, 1'b0, 1'b0);
        queue_vertex(32'h0000_0022, ptwe_pkg::MODE_QSTRIP, 1'b0, 1'b1);
        // unknown mode, then a one-vertex strip
        queue_vertex(32'h1234_5678, 4'hF, 1'b1, 1'b1);
        queue_vertex(32'h8765_4321, ptwe_pkg::MODE_TSTRIP, 1'b1, 1'b1);

        // random runs, mostly well formed
        hold_at  = vertex_q.size();
        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 8)
                mode = 4'($urandom_range(10, 15));
            else
                mode = 4'($urandom_range(0, 9));
            case (mode)
                ptwe_pkg::MODE_TRIS:
                    len = 3 * $urandom_range(1, 4)
                          + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
                ptwe_pkg::MODE_QUADS:
                    len = 4 * $urandom_range(1, 3)
                          + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
                ptwe_pkg::MODE_QSTRIP: len = $urandom_range(2, 12);
                default:               len = $urandom_range(1, 8);
            endcase
            queue_run(mode, len, $urandom_range(0, 9) != 0);
            n_random += len;
            // stray vertex with no start flag
            if ($urandom_range(0, 9) == 0)
            begin
                queue_vertex(pick_index(), 4'($urandom), 1'b0, 1'($urandom));
                n_random++;
            end
        end
        vertex_q[hold_at].drain_first = 1'b1;
        total_items = vertex_q.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!(n_sent == total_items && n_expected == n_checked))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (due_edges.size() != 0)
            $display("missing %0d expected edge transfers", due_edges.size());
        if (mismatches == 0 && due_edges.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // vertex driver: bursts with random gaps, optional drain before an item
    always @(posedge clk or negedge rst_n)
    begin
        bit fire;
        bit go;
        int produced;
        if (!rst_n)
        begin
            vertex_valid       <= 1'b0;
            vertex_index       <= '0;
            prim_mode          <= '0;
            start_of_primitive <= 1'b0;
            end_of_primitive   <= 1'b0;
            n_sent             <= 0;
            n_expected         <= 0;
            burst_left          = $urandom_range(1, 16);
            gap_left            = 0;
            // predictor run state as after reset
            run_mode            = ptwe_pkg::MODE_POINTS;
            seen                = 2'd0;
            phase               = 2'd0;
            anchor              = '0;
            recent[0]           = '0;
            recent[1]           = '0;
            recent[2]           = '0;
        end
        else
        begin
            fire = vertex_valid && !vertex_stall;
            if (fire)
            begin
                produced = derive_edges(cur_vertex);
                n_expected <= n_expected + produced;
                n_sent     <= n_sent + 1;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                              : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            if (!vertex_valid || fire)
            begin
                go = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (vertex_q.size() != 0)
                    go = !(vertex_q[0].drain_first && (fire || n_expected != n_checked));
                if (go)
                begin
                    cur_vertex         = vertex_q.pop_front();
                    vertex_index       <= cur_vertex.idx;
                    prim_mode          <= cur_vertex.mode;
                    start_of_primitive <= cur_vertex.sop;
                    end_of_primitive   <= cur_vertex.eop;
                end
                vertex_valid <= go;
            end
        end
    end

    // edge monitor and stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        edge_rec_t got;
        edge_rec_t want;
        if (!rst_n)
        begin
            edge_stall <= 1'b0;
            n_checked  <= 0;
            mismatches  = 0;
            stall_win   = 0;
            stall_pct   = 0;
        end
        else
        begin
            if (edge_valid && !edge_stall)
            begin
                got = '{result_kind, pass_mode, edge_from, edge_to, primitive_end,
                        last_of_run};
                if (due_edges.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected edge: kind %0d mode %0d %h %h end %0d last %0d",
                                 got.kind, got.pmode, got.e_from, got.e_to, got.pend,
                                 got.last);
                end
                else
                begin
                    want = due_edges.pop_front();
                    n_checked <= n_checked + 1;
                    if (got.kind !== want.kind || got.pmode !== want.pmode ||
                        got.e_from !== want.e_from || got.e_to !== want.e_to ||
                        got.pend !== want.pend || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("expected: %0d %0d %h %h end %0d last %0d",
                                     want.kind, want.pmode, want.e_from, want.e_to,
                                     want.pend, want.last);
                            $display("actual:   %0d %0d %h %h end %0d last %0d",
                                     got.kind, got.pmode, got.e_from, got.e_to,
                                     got.pend, got.last);
                        end
                    end
                end
            end
            // stall density changes from window to window, some with none
            if (stall_win == 0)
            begin
                stall_win = $urandom_range(16, 80);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            stall_win--;
            edge_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((vertex_valid && !vertex_stall) || (edge_valid && !edge_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
        else
        begin
            idle_cycles = 0;
        end
    end

endmodule
